FILE: sv/imuma_pkg.sv
// Shared types and constants for the IMU three-axis moving average.
// No dependencies; every other file refers to it by scoped names.
package imuma_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int SUM_W      = 24;
    localparam int FRAC_W     = 8;
    localparam int DEPTH_W    = 8;
    localparam int RECIP_W    = 32;
    localparam int RECIP_SH   = 31;
    localparam int NUM_STAGES = 5;
    localparam int NUM_AXES   = 3;

    typedef enum logic [1:0] {
        GRP_ACCEL = 2'd0,
        GRP_GYRO  = 2'd1,
        GRP_MAG   = 2'd2,
        GRP_NONE  = 2'd3
    } t_group;

    typedef logic signed [SAMPLE_W-1:0] t_sample;
    typedef logic signed [SUM_W-1:0]    t_sum;

    // One tap of history: the three axes of one reading
    typedef struct packed {
        t_sample z;
        t_sample y;
        t_sample x;
    } t_axes;

    // Stage controls shared by the three per-axis mean pipelines
    typedef struct packed {
        logic [NUM_STAGES-1:0] ld;
        logic [RECIP_W-1:0]    recip;
        logic [DEPTH_W-1:0]    depth;
    } t_mean_ctl;

endpackage

FILE: sv/imuma_cell.sv
// One history cell: holds the three axis samples of one past reading.
// Depends on imuma_pkg.
module imuma_cell (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  imuma_pkg::t_axes i_d,
    output imuma_pkg::t_axes o_q
);

    imuma_pkg::t_axes r_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q <= '0;
        end else if (i_load) begin
            r_q <= i_d;
        end
    end

    assign o_q = r_q;

endmodule

FILE: sv/imuma_line.sv
// Chain of history cells for one sensor group; the last cell is the oldest sample.
// Depends on imuma_pkg and imuma_cell.
module imuma_line #(
    parameter int DEPTH = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_shift,
    input  imuma_pkg::t_axes i_sample,
    output imuma_pkg::t_axes o_oldest
);

    imuma_pkg::t_axes w_tap [DEPTH+1];

    assign w_tap[0] = i_sample;

    // advance every cell by one place on each reading of this group
    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        imuma_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_load  (i_shift),
            .i_d     (w_tap[i]),
            .o_q     (w_tap[i+1])
        );
    end

    assign o_oldest = w_tap[DEPTH];

endmodule

FILE: sv/imuma_mean.sv
// Per-axis scaling pipeline: sum*256/depth truncated toward zero, by reciprocal.
// Depends on imuma_pkg; stage loads and constants come from the top level.
module imuma_mean (
    input  logic                 i_clk,
    input  imuma_pkg::t_mean_ctl i_ctl,
    input  imuma_pkg::t_sum      i_sum,
    output imuma_pkg::t_sum      o_mean
);

    localparam int NUM_W  = imuma_pkg::SUM_W - 1 + imuma_pkg::FRAC_W;
    localparam int PROD_W = NUM_W + imuma_pkg::RECIP_W;
    localparam int Q_W    = imuma_pkg::SUM_W;

    imuma_pkg::t_sum            r_s0;
    logic                       r_neg1, r_neg2, r_neg3;
    logic [Q_W-1:0]             r_mag1;
    logic [NUM_W-1:0]           r_n2;
    logic [Q_W-1:0]             r_q2, r_q3;
    imuma_pkg::t_sum            r_mean4;

    logic [NUM_W-1:0]           w_n1;
    logic [PROD_W-1:0]          w_prod;
    logic [NUM_W:0]             w_dq;
    logic [NUM_W:0]             w_rem;

    // numerator |sum| * 256; the magnitude never reaches 2^23
    assign w_n1   = {r_mag1[Q_W-2:0], {imuma_pkg::FRAC_W{1'b0}}};
    assign w_prod = PROD_W'(w_n1) * PROD_W'(i_ctl.recip);
    assign w_dq   = (NUM_W+1)'(r_q2) * (NUM_W+1)'(i_ctl.depth);
    assign w_rem  = {1'b0, r_n2} - w_dq;

    always_ff @(posedge i_clk) begin
        if (i_ctl.ld[0]) begin
            r_s0 <= i_sum;
        end
        if (i_ctl.ld[1]) begin
            r_neg1 <= r_s0[imuma_pkg::SUM_W-1];
            r_mag1 <= r_s0[imuma_pkg::SUM_W-1] ? Q_W'(-r_s0) : Q_W'(r_s0);
        end
        if (i_ctl.ld[2]) begin
            r_neg2 <= r_neg1;
            r_n2   <= w_n1;
            r_q2   <= w_prod[imuma_pkg::RECIP_SH +: Q_W];
        end
        if (i_ctl.ld[3]) begin
            // estimate is low by at most one; fix with one compare
            r_neg3 <= r_neg2;
            r_q3   <= (w_rem >= (NUM_W+1)'(i_ctl.depth)) ? r_q2 + 1'b1 : r_q2;
        end
        if (i_ctl.ld[4]) begin
            r_mean4 <= r_neg3 ? imuma_pkg::t_sum'(-r_q3) : imuma_pkg::t_sum'(r_q3);
        end
    end

    assign o_mean = r_mean4;

endmodule

FILE: sv/imu_three_axis_moving_average.sv
// IMU three-axis boxcar moving average, one history chain of cells per sensor group.
// Accepted items load stage 0 and move on through stages 1 to 4, the output register.
// One item per cycle while not stalled; stages advance independently, so bubbles close up.
// Reset (i_rst_n low, synchronous): history cells and running sums clear to zero,
// the pipeline empties. Group code 3 is taken and dropped without a result.
// Depends on imuma_pkg, imuma_line, imuma_cell and imuma_mean.
module imu_three_axis_moving_average #(
    parameter int ACCEL_DEPTH = 16,
    parameter int GYRO_DEPTH  = 16,
    parameter int MAG_DEPTH   = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // slave side: readings
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [47:0] i_s_axis_tdata,   // sample_x[15:0], sample_y[31:16], sample_z[47:32]
    input  logic [1:0]  i_s_axis_tuser,   // sensor_group[1:0]
    // master side: window averages
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [71:0] o_m_axis_tdata,   // mean_x[23:0], mean_y[47:24], mean_z[71:48]
    output logic [1:0]  o_m_axis_tuser    // group_out[1:0]
);

    localparam int NS = imuma_pkg::NUM_STAGES;
    localparam int NA = imuma_pkg::NUM_AXES;

    // reciprocals floor(2^31 / depth), worked out at elaboration
    localparam logic [imuma_pkg::RECIP_W-1:0] ACCEL_RECIP =
        imuma_pkg::RECIP_W'((64'd1 << imuma_pkg::RECIP_SH) / ACCEL_DEPTH);
    localparam logic [imuma_pkg::RECIP_W-1:0] GYRO_RECIP =
        imuma_pkg::RECIP_W'((64'd1 << imuma_pkg::RECIP_SH) / GYRO_DEPTH);
    localparam logic [imuma_pkg::RECIP_W-1:0] MAG_RECIP =
        imuma_pkg::RECIP_W'((64'd1 << imuma_pkg::RECIP_SH) / MAG_DEPTH);

    imuma_pkg::t_group    w_grp_in;
    imuma_pkg::t_axes     w_sample;
    logic                 w_acc;
    logic [NS-1:0]        w_en;

    imuma_pkg::t_axes     w_old_acc, w_old_gyr, w_old_mag, w_oldest;
    imuma_pkg::t_sample   w_new [NA];
    imuma_pkg::t_sample   w_old [NA];
    imuma_pkg::t_sum      w_sum_cur [NA];
    imuma_pkg::t_sum      w_sum_new [NA];
    imuma_pkg::t_sum      w_mean [NA];

    imuma_pkg::t_sum      r_sum [3][NA];     // running sums, [group][axis]
    logic [NS-1:0]        r_v;               // stage valid bits
    imuma_pkg::t_group    r_grp [NS];        // group travelling with each stage
    imuma_pkg::t_mean_ctl w_ctl;

    assign w_grp_in = imuma_pkg::t_group'(i_s_axis_tuser);
    assign w_sample = imuma_pkg::t_axes'(i_s_axis_tdata);

    // A stage loads when it is empty or its successor loads; the last stage
    // frees up when the output item is taken.
    always_comb begin
        w_en[NS-1] = !r_v[NS-1] || i_m_axis_tready;
        for (int k = NS - 2; k >= 0; k--) begin
            w_en[k] = !r_v[k] || w_en[k+1];
        end
    end

    assign o_s_axis_tready = w_en[0];
    assign w_acc           = i_s_axis_tvalid && w_en[0];

    // history chains: shift only on a reading of their own group
    imuma_line #(.DEPTH(ACCEL_DEPTH)) u_line_accel (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_shift  (w_acc && (w_grp_in == imuma_pkg::GRP_ACCEL)),
        .i_sample (w_sample),
        .o_oldest (w_old_acc)
    );

    imuma_line #(.DEPTH(GYRO_DEPTH)) u_line_gyro (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_shift  (w_acc && (w_grp_in == imuma_pkg::GRP_GYRO)),
        .i_sample (w_sample),
        .o_oldest (w_old_gyr)
    );

    imuma_line #(.DEPTH(MAG_DEPTH)) u_line_mag (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_shift  (w_acc && (w_grp_in == imuma_pkg::GRP_MAG)),
        .i_sample (w_sample),
        .o_oldest (w_old_mag)
    );

    // Select the oldest sample and current sums of the incoming group.
    // Sums update in the accept cycle, so a following item sees them at once.
    always_comb begin
        unique case (w_grp_in)
            imuma_pkg::GRP_ACCEL: w_oldest = w_old_acc;
            imuma_pkg::GRP_GYRO:  w_oldest = w_old_gyr;
            default:              w_oldest = w_old_mag;
        endcase
        w_new[0] = w_sample.x;
        w_new[1] = w_sample.y;
        w_new[2] = w_sample.z;
        w_old[0] = w_oldest.x;
        w_old[1] = w_oldest.y;
        w_old[2] = w_oldest.z;
        for (int a = 0; a < NA; a++) begin
            unique case (w_grp_in)
                imuma_pkg::GRP_ACCEL: w_sum_cur[a] = r_sum[0][a];
                imuma_pkg::GRP_GYRO:  w_sum_cur[a] = r_sum[1][a];
                default:              w_sum_cur[a] = r_sum[2][a];
            endcase
            // drop the oldest sample, add the new one; always fits in 24 bits
            w_sum_new[a] = w_sum_cur[a]
                         - imuma_pkg::t_sum'(w_old[a])
                         + imuma_pkg::t_sum'(w_new[a]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int g = 0; g < 3; g++) begin
                for (int a = 0; a < NA; a++) begin
                    r_sum[g][a] <= '0;
                end
            end
        end else if (w_acc) begin
            for (int a = 0; a < NA; a++) begin
                unique case (w_grp_in)
                    imuma_pkg::GRP_ACCEL: r_sum[0][a] <= w_sum_new[a];
                    imuma_pkg::GRP_GYRO:  r_sum[1][a] <= w_sum_new[a];
                    imuma_pkg::GRP_MAG:   r_sum[2][a] <= w_sum_new[a];
                    imuma_pkg::GRP_NONE:  r_sum[2][a] <= r_sum[2][a];
                endcase
            end
        end
    end

    // Stage valids: an invalid group leaves a bubble instead of an item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_en[0]) begin
                r_v[0] <= w_acc && (w_grp_in != imuma_pkg::GRP_NONE);
            end
            for (int k = 1; k < NS; k++) begin
                if (w_en[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    // Group codes travel beside the data; no reset needed
    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r_grp[0] <= w_grp_in;
        end
        for (int k = 1; k < NS; k++) begin
            if (w_en[k]) begin
                r_grp[k] <= r_grp[k-1];
            end
        end
    end

    // Constants per stage: reciprocal for the multiply out of stage 1,
    // depth for the correction out of stage 2
    always_comb begin
        w_ctl.ld = w_en;
        unique case (r_grp[1])
            imuma_pkg::GRP_ACCEL: w_ctl.recip = ACCEL_RECIP;
            imuma_pkg::GRP_GYRO:  w_ctl.recip = GYRO_RECIP;
            default:              w_ctl.recip = MAG_RECIP;
        endcase
        unique case (r_grp[2])
            imuma_pkg::GRP_ACCEL: w_ctl.depth = imuma_pkg::DEPTH_W'(ACCEL_DEPTH);
            imuma_pkg::GRP_GYRO:  w_ctl.depth = imuma_pkg::DEPTH_W'(GYRO_DEPTH);
            default:              w_ctl.depth = imuma_pkg::DEPTH_W'(MAG_DEPTH);
        endcase
    end

    for (genvar a = 0; a < NA; a++) begin : g_axis
        imuma_mean u_mean (
            .i_clk  (i_clk),
            .i_ctl  (w_ctl),
            .i_sum  (w_sum_new[a]),
            .o_mean (w_mean[a])
        );
    end

    assign o_m_axis_tvalid = r_v[NS-1];
    assign o_m_axis_tuser  = r_grp[NS-1];
    assign o_m_axis_tdata  = {w_mean[2], w_mean[1], w_mean[0]};

endmodule
